### hdl/assert_macros.svh
// Assertion macros used by the RTL of the line breaker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### hdl/glb_pkg.sv
// Types and constants of the greedy line breaker.
package glb_pkg;

   // Widths fixed by the transaction formats.
   localparam int ADVANCE_W  = 16;
   localparam int LINE_W     = 22;
   localparam int INDEX_W    = 6;

   // Default store capacity in glyphs.
   localparam int MAX_GLYPHS = 64;

   // Input transaction: one glyph.
   typedef struct packed {
      logic [ADVANCE_W-1:0] advance;
      logic                 may_break;
      logic                 must_break;
      logic                 last_glyph;
   } req_payload_type;

   // Result transaction: the final break flag of one glyph.
   typedef struct packed {
      logic [INDEX_W-1:0] glyph_index;
      logic               break_before;
      logic               overflow;
      logic               last_result;
   } rsp_payload_type;

   // One entry of the glyph store.
   typedef struct packed {
      logic                 must;
      logic                 may;
      logic [ADVANCE_W-1:0] advance;
   } glyph_entry_type;

endpackage

### hdl/glb_stream_if.sv
// Valid/ready stream interface used by both channels of the line breaker.
interface glb_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hdl/greedy_line_breaker.sv
// Greedy line breaker: glyph store, wrap sequencer and result emission.
//
// Usage: glyphs arrive on req_chan, one transaction each, carrying an advance
// width and soft/hard break flags. A transaction with last_glyph set closes
// the paragraph. Up to MAX_GLYPHS glyphs are stored; later ones are dropped
// and every result of that paragraph reports overflow.
// The user must write the available width through csr_wr_en/csr_wr_data
// while the block is idle; the block does not enforce it. It is used in the wrap.
// Loading can take one glyph per cycle. The wrap then walks the store
// through a single read port and one shared add-and-compare unit, reading
// each glyph visited in ST_WRAP_RD and evaluating it in ST_WRAP_EVAL; a
// backtrack after a soft break revisits the glyphs of the line that did not
// fit. Results leave on rsp_chan in paragraph order, one per stored glyph,
// each read in ST_EMIT_RD and held in ST_EMIT_OUT until it is taken.
// req_chan.ready is low from the last glyph until the final result is taken.
// A stalled receiver simply holds the current result in its output register.
// Reset (synchronous, active high) empties the paragraph, clears the line
// width and returns the block to loading. The store itself is not cleared.
module greedy_line_breaker #(
   parameter int MAX_GLYPHS = glb_pkg::MAX_GLYPHS
) (
   input  logic                          clock,
   input  logic                          reset,
   glb_stream_if.sink                    req_chan,
   glb_stream_if.source                  rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [glb_pkg::LINE_W-1:0]    csr_wr_data
);

`include "assert_macros.svh"

   localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
   localparam int CW = $clog2(MAX_GLYPHS + 1);
   localparam int LW = glb_pkg::LINE_W;
   localparam int IW = glb_pkg::INDEX_W;

   // Sequencer states.
   localparam logic [2:0] ST_LOAD      = 3'd0;
   localparam logic [2:0] ST_WRAP_RD   = 3'd1;
   localparam logic [2:0] ST_WRAP_EVAL = 3'd2;
   localparam logic [2:0] ST_EMIT_RD   = 3'd3;
   localparam logic [2:0] ST_EMIT_OUT  = 3'd4;

   // Registers and their next values.
   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  overflow_ff, overflow_in;
   logic [LW-1:0]         line_width_ff;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [LW-1:0]         run_width_ff, run_width_in;
   logic [CW-1:0]         brk_pt_ff, brk_pt_in;
   logic                  brk_valid_ff, brk_valid_in;
   logic                  brk_allowed_ff, brk_allowed_in;
   logic                  forced_ff, forced_in;

   // Glyph store and its registered read data.
   glb_pkg::glyph_entry_type glyph_store_ff [MAX_GLYPHS];
   glb_pkg::glyph_entry_type rd_data_ff;

   // Memory port controls.
   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   glb_pkg::glyph_entry_type mem_wdata;
   logic                     mem_re;
   logic [AW-1:0]            mem_raddr;

   // Shared evaluation unit signals.
   logic                  req_fire;
   logic                  rsp_fire;
   logic                  glyph_must;
   logic                  soft_here;
   logic                  brk_valid_eff;
   logic [CW-1:0]         brk_pt_eff;
   logic [CW-1:0]         pos_next;
   logic [CW-1:0]         new_brk;
   logic [LW:0]           width_sum;
   logic                  fits;
   glb_pkg::glyph_entry_type new_entry;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_LOAD);
   assign rsp_chan.valid = (state_ff == ST_EMIT_OUT);

   // Result payload; the break flag comes straight from the registered read data.
   assign rsp_chan.payload.glyph_index  = IW'(pos_ff);
   assign rsp_chan.payload.break_before = rd_data_ff.must;
   assign rsp_chan.payload.overflow     = overflow_ff;
   assign rsp_chan.payload.last_result  = ((pos_ff + CW'(1)) == count_ff);

   // Incoming glyph as a store entry.
   assign new_entry.must    = req_chan.payload.must_break;
   assign new_entry.may     = req_chan.payload.may_break;
   assign new_entry.advance = req_chan.payload.advance;

   // Add-and-compare unit for the glyph just read.
   assign glyph_must    = rd_data_ff.must || forced_ff;
   assign soft_here     = brk_allowed_ff && rd_data_ff.may;
   assign brk_valid_eff = brk_valid_ff || soft_here;
   assign brk_pt_eff    = soft_here ? pos_ff : brk_pt_ff;
   assign pos_next      = pos_ff + CW'(1);
   assign width_sum     = {1'b0, run_width_ff} + (LW + 1)'(rd_data_ff.advance);
   assign fits          = (width_sum < {1'b0, line_width_ff});

   // Break point chosen when the glyph does not fit.
   always_comb begin
      if (run_width_ff == '0) begin
         new_brk = pos_next;
      end else if (!brk_valid_eff) begin
         new_brk = pos_ff;
      end else begin
         new_brk = brk_pt_eff;
      end
   end

   // Sequencer and memory port control.
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      overflow_in    = overflow_ff;
      pos_in         = pos_ff;
      run_width_in   = run_width_ff;
      brk_pt_in      = brk_pt_ff;
      brk_valid_in   = brk_valid_ff;
      brk_allowed_in = brk_allowed_ff;
      forced_in      = forced_ff;
      mem_we         = 1'b0;
      mem_waddr      = count_ff[AW-1:0];
      mem_wdata      = new_entry;
      mem_re         = 1'b0;
      mem_raddr      = pos_ff[AW-1:0];

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               if (count_ff < CW'(MAX_GLYPHS)) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_chan.payload.last_glyph) begin
                  state_in       = ST_WRAP_RD;
                  pos_in         = '0;
                  run_width_in   = '0;
                  brk_pt_in      = '0;
                  brk_valid_in   = 1'b0;
                  brk_allowed_in = 1'b0;
                  forced_in      = 1'b0;
               end
            end
         end

         ST_WRAP_RD: begin
            if (pos_ff < count_ff) begin
               mem_re   = 1'b1;
               state_in = ST_WRAP_EVAL;
            end else begin
               pos_in   = '0;
               state_in = ST_EMIT_RD;
            end
         end

         ST_WRAP_EVAL: begin
            state_in  = ST_WRAP_RD;
            forced_in = 1'b0;
            // A forced break is written back into the store.
            if (forced_ff) begin
               mem_we         = 1'b1;
               mem_waddr      = pos_ff[AW-1:0];
               mem_wdata      = rd_data_ff;
               mem_wdata.must = 1'b1;
            end
            if (glyph_must) begin
               run_width_in   = LW'(rd_data_ff.advance);
               brk_valid_in   = 1'b0;
               brk_allowed_in = 1'b0;
               pos_in         = pos_next;
            end else if (fits) begin
               run_width_in   = width_sum[LW-1:0];
               brk_valid_in   = brk_valid_eff;
               brk_pt_in      = brk_pt_eff;
               brk_allowed_in = 1'b1;
               pos_in         = pos_next;
            end else begin
               pos_in         = new_brk;
               brk_pt_in      = new_brk;
               forced_in      = (new_brk < count_ff);
               run_width_in   = '0;
               brk_valid_in   = 1'b0;
               brk_allowed_in = 1'b0;
            end
         end

         ST_EMIT_RD: begin
            mem_re   = 1'b1;
            state_in = ST_EMIT_OUT;
         end

         ST_EMIT_OUT: begin
            if (rsp_fire) begin
               if (pos_next == count_ff) begin
                  count_in    = '0;
                  overflow_in = 1'b0;
                  state_in    = ST_LOAD;
               end else begin
                  pos_in   = pos_next;
                  state_in = ST_EMIT_RD;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_LOAD;
         count_ff       <= '0;
         overflow_ff    <= 1'b0;
         line_width_ff  <= '0;
         pos_ff         <= '0;
         run_width_ff   <= '0;
         brk_pt_ff      <= '0;
         brk_valid_ff   <= 1'b0;
         brk_allowed_ff <= 1'b0;
         forced_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         overflow_ff    <= overflow_in;
         pos_ff         <= pos_in;
         run_width_ff   <= run_width_in;
         brk_pt_ff      <= brk_pt_in;
         brk_valid_ff   <= brk_valid_in;
         brk_allowed_ff <= brk_allowed_in;
         forced_ff      <= forced_in;
         if (csr_wr_en) begin
            line_width_ff <= csr_wr_data;
         end
      end
   end

   // Glyph store write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         glyph_store_ff[mem_waddr] <= mem_wdata;
      end
   end

   // Glyph store read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= glyph_store_ff[mem_raddr];
      end
   end

   // The store fill never passes its capacity.
   `ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(MAX_GLYPHS))

   // The wrap only evaluates glyphs that were stored in this paragraph.
   `ASSERT_SAME(a_eval_in_range, clock, reset, state_ff == ST_WRAP_EVAL, pos_ff < count_ff)

   // A glyph other than the last one, taken by a full store, raises the overflow flag.
   `ASSERT_NEXT(a_overflow_set, clock, reset,
      req_fire && (count_ff == CW'(MAX_GLYPHS)) && !req_chan.payload.last_glyph,
      overflow_ff)

   // Taking the final result empties the paragraph and reopens loading.
   `ASSERT_NEXT(a_paragraph_done, clock, reset,
      rsp_fire && rsp_chan.payload.last_result,
      (state_ff == ST_LOAD) && (count_ff == '0) && !overflow_ff)

endmodule

### tb/testbench.sv
// Self-checking testbench for the greedy line breaker, with a line-wrap scoreboard.
`timescale 1ns / 100ps

import glb_pkg::*;

// Predicts the break flags of each paragraph and checks the result transactions.
class wrap_scoreboard;
   glyph_entry_type paragraph[MAX_GLYPHS];
   int unsigned     glyph_total;
   bit              dropped_glyphs;
   int unsigned     line_width;
   rsp_payload_type expected_breaks[$];
   int unsigned     failures;

   function void set_line_width(input logic [LINE_W-1:0] value);
      line_width = value;
   endfunction

   function int unsigned pending();
      return expected_breaks.size();
   endfunction

   // Greedy walk over the stored paragraph; forced breaks become hard breaks.
   function void wrap_paragraph();
      int unsigned pos;
      int unsigned run;
      int unsigned mark;
      int unsigned adv;
      bit          mark_valid;
      bit          soft_ok;
      pos = 0;
      run = 0;
      mark = 0;
      mark_valid = 1'b0;
      soft_ok = 1'b0;
      while (pos < glyph_total) begin
         adv = paragraph[pos].advance;
         if (paragraph[pos].must) begin
            // A hard break starts a new line holding this glyph.
            run = adv;
            mark_valid = 1'b0;
            soft_ok = 1'b0;
            pos++;
         end else begin
            if (soft_ok && paragraph[pos].may) begin
               mark_valid = 1'b1;
               mark = pos;
            end
            if (run + adv < line_width) begin
               run += adv;
               pos++;
               soft_ok = 1'b1;
            end else begin
               // The glyph does not fit: pick the break and walk again from it.
               if (run == 0)
                  mark = pos + 1;
               else if (!mark_valid)
                  mark = pos;
               pos = mark;
               if (pos < glyph_total)
                  paragraph[pos].must = 1'b1;
               run = 0;
               mark_valid = 1'b0;
               soft_ok = 1'b0;
            end
         end
      end
   endfunction

   // Records an accepted glyph; the last one of a paragraph yields its results.
   function void note_glyph(input req_payload_type g);
      rsp_payload_type r;
      int unsigned     i;
      if (glyph_total < MAX_GLYPHS) begin
         paragraph[glyph_total].advance = g.advance;
         paragraph[glyph_total].may = g.may_break;
         paragraph[glyph_total].must = g.must_break;
         glyph_total++;
      end else begin
         dropped_glyphs = 1'b1;
      end
      if (g.last_glyph) begin
         wrap_paragraph();
         for (i = 0; i < glyph_total; i++) begin
            r.glyph_index = INDEX_W'(i);
            r.break_before = paragraph[i].must;
            r.overflow = dropped_glyphs;
            r.last_result = (i + 1 == glyph_total);
            expected_breaks.push_back(r);
         end
         glyph_total = 0;
         dropped_glyphs = 1'b0;
      end
   endfunction

   function void compare_field(input string name, input int unsigned index,
                               input int unsigned want, input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch at glyph %0d: expected %0d, actual %0d",
                  $time, name, index, want, got);
         failures++;
      end
   endfunction

   // Compares one result transaction with the oldest prediction.
   function void check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (expected_breaks.size() == 0) begin
         $display("%0t: unexpected result: expected none, actual index %0d",
                  $time, got.glyph_index);
         failures++;
      end else begin
         want = expected_breaks.pop_front();
         compare_field("glyph_index", want.glyph_index, want.glyph_index,
                       got.glyph_index);
         compare_field("break_before", want.glyph_index, want.break_before,
                       got.break_before);
         compare_field("overflow", want.glyph_index, want.overflow, got.overflow);
         compare_field("last_result", want.glyph_index, want.last_result,
                       got.last_result);
      end
   endfunction
endclass

module testbench;

   localparam int unsigned TOTAL_ITEMS   = 420;
   localparam int unsigned SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam logic [LINE_W-1:0] WIDTH_MAX = {LINE_W{1'b1}};

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [LINE_W-1:0] csr_wr_data;

   glb_stream_if #(.payload_type(req_payload_type)) req_if ();
   glb_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();

   wrap_scoreboard sb = new();

   int unsigned items_sent;
   int unsigned burst_left;
   int unsigned cycle_count;
   int unsigned stall_cycles;
   logic [15:0] stall_pattern = 16'hFFFF;

   greedy_line_breaker dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Clock with a 2 ns period.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver ready follows a rotating stall pattern that changes every so often.
   always @(negedge clock) begin
      if (stall_cycles == 0) begin
         stall_cycles = $urandom_range(60, 200);
         case ($urandom_range(0, 3))
            0: stall_pattern = 16'hFFFF;
            1: stall_pattern = 16'($urandom());
            2: stall_pattern = 16'h8001;
            default: stall_pattern = 16'($urandom()) | 16'($urandom());
         endcase
      end
      stall_cycles--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      rsp_if.ready <= stall_pattern[0];
   end

   // Every accepted result transaction is checked at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.payload);
   end

   function automatic req_payload_type glyph(input int unsigned adv, input bit may,
                                             input bit must, input bit last);
      req_payload_type p;
      p.advance = ADVANCE_W'(adv);
      p.may_break = may;
      p.must_break = must;
      p.last_glyph = last;
      return p;
   endfunction

   // Sends one glyph in bursts separated by random gaps; returns at a falling edge.
   task automatic send_glyph(input req_payload_type p);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 50 : $urandom_range(1, 10);
      end
      burst_left--;
      req_if.valid <= 1'b1;
      req_if.payload <= p;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_glyph(p);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_glyphs(input req_payload_type glyphs[$]);
      foreach (glyphs[i])
         send_glyph(glyphs[i]);
   endtask

   // Holds the sender until every predicted result has been taken.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_line_width(input logic [LINE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_line_width(value);
   endtask

   // One well-formed paragraph with advances mostly scaled to the current line width.
   task automatic send_random_paragraph(input int unsigned len, input int unsigned max_adv);
      req_payload_type p;
      int unsigned     i;
      int unsigned     pick;
      for (i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 5)
            p.advance = '0;
         else if (pick < 10)
            p.advance = '1;
         else if (pick < 25)
            p.advance = ADVANCE_W'($urandom_range(0, 65535));
         else
            p.advance = ADVANCE_W'($urandom_range(0, max_adv));
         p.may_break = ($urandom_range(0, 99) < 35);
         p.must_break = ($urandom_range(0, 99) < 6);
         p.last_glyph = (i + 1 == len);
         send_glyph(p);
      end
   endtask

   initial begin
      req_payload_type directed[$];
      int unsigned     para;
      int unsigned     len;
      int unsigned     width;
      int unsigned     max_adv;

      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // Zero line width: every glyph that is not a hard break breaks after itself.
      write_line_width('0);
      directed = '{glyph(0, 1, 0, 0), glyph(65535, 0, 0, 0), glyph(100, 0, 1, 1)};
      send_glyphs(directed);
      wait_drained();

      // Widest line: a lone hard-break glyph, then a paragraph that fits but for its closing hard break.
      write_line_width(WIDTH_MAX);
      directed = '{glyph(65535, 0, 1, 1), glyph(65535, 1, 0, 0), glyph(65535, 0, 0, 0),
                   glyph(65535, 1, 0, 0), glyph(0, 1, 1, 1)};
      send_glyphs(directed);
      wait_drained();

      // Soft-break backtrack, a glyph wider than the line, a hard break, and a
      // line with no soft break opportunity.
      write_line_width(22'd1000);
      directed = '{glyph(300, 0, 0, 0), glyph(300, 1, 0, 0), glyph(300, 0, 0, 0),
                   glyph(300, 1, 0, 0), glyph(1200, 0, 0, 0), glyph(200, 0, 1, 0),
                   glyph(400, 0, 0, 0), glyph(400, 0, 0, 0), glyph(400, 0, 0, 1)};
      send_glyphs(directed);
      wait_drained();

      // Unit width: zero advances fit, a unit advance on an empty line does not.
      write_line_width(22'd1);
      directed = '{glyph(0, 0, 0, 0), glyph(0, 1, 0, 0), glyph(1, 0, 0, 1)};
      send_glyphs(directed);

      // Random paragraphs, with the line width changed between some of them.
      para = 0;
      width = 1;
      while (items_sent < TOTAL_ITEMS) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_drained();
            case ($urandom_range(0, 7))
               0: width = 0;
               1: width = WIDTH_MAX;
               2: width = $urandom_range(1, 64);
               3, 4, 5: width = $urandom_range(1000, 200000);
               6: width = $urandom_range(0, WIDTH_MAX);
               default: width = $urandom_range(65536, 400000);
            endcase
            write_line_width(LINE_W'(width));
         end
         if (para == 2)
            len = MAX_GLYPHS + 1;
         else if (para == 5)
            len = MAX_GLYPHS;
         else if ($urandom_range(0, 19) == 0)
            len = $urandom_range(MAX_GLYPHS - 4, MAX_GLYPHS + 8);
         else
            len = $urandom_range(1, 16);
         max_adv = width / 3 + 1;
         if (max_adv > 65535)
            max_adv = 65535;
         send_random_paragraph(len, max_adv);
         para++;
      end

      wait_drained();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

### greedy_line_breaker.f
+incdir+hdl
hdl/glb_pkg.sv
hdl/glb_stream_if.sv
hdl/greedy_line_breaker.sv
tb/testbench.sv
